// ===== sv/mbe_pkg.sv =====
package mbe_pkg;

    // Array geometry
    localparam int LANES         = 4;
    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 600;
    localparam int OUT_LANES     = 4;

    // Field widths
    localparam int ROW_W  = 10;
    localparam int GCOL_W = 8;
    localparam int COL_W  = 10;
    localparam int CNT_W  = 16;
    localparam int R2_W   = 31;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    // Fixed point Q8.24
    localparam int Q_W     = 32;
    localparam int FRAC    = 24;
    localparam int OFF_W   = 14;              // signed pixel offset from screen center
    localparam int MPROD_W = OFF_W + Q_W;     // offset times step
    localparam int SUM_W   = MPROD_W + 1;     // origin plus offset product
    localparam int PROD_W  = 2 * Q_W;         // full coordinate product
    localparam int SQ_W    = PROD_W - FRAC;   // product back at Q8.24, no wrap
    localparam int NEXT_W  = SQ_W + 2;        // new coordinate before clamp

    // Register reset values
    localparam logic signed [Q_W-1:0] X_ORIGIN_RST = '0;
    localparam logic signed [Q_W-1:0] Y_ORIGIN_RST = '0;
    localparam logic signed [Q_W-1:0] X_STEP_RST   = 32'sd83886;
    localparam logic signed [Q_W-1:0] Y_STEP_RST   = 32'sd83886;
    localparam logic [CNT_W-1:0]      MAX_ITER_RST = 16'd256;
    localparam logic [R2_W-1:0]       ESC_R2_RST   = 31'd1677721600;

    typedef enum logic [IDX_W-1:0] {
        CFG_X_ORIGIN  = 3'd0,
        CFG_Y_ORIGIN  = 3'd1,
        CFG_X_STEP    = 3'd2,
        CFG_Y_STEP    = 3'd3,
        CFG_MAX_ITER  = 3'd4,
        CFG_ESCAPE_R2 = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MUL,
        S_UPD,
        S_DRAIN
    } t_state;

    // Sequencer to lane controls
    typedef struct packed {
        logic accept;   // word taken: start offset products
        logic map;      // form c, seed z = c
        logic mul;      // square products
        logic upd;      // escape test and z update
    } t_lane_ctl;

    // Clamp to signed 32 bits
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-Q_W:0] hi;
        logic signed [Q_W-1:0] res;
        hi = v[SUM_W-1:Q_W-1];
        if ((hi == '0) || (hi == '1)) begin
            res = v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(Q_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== sv/mbe_in_if.sv =====
interface mbe_in_if;
    import mbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  pixel_row;
    logic [GCOL_W-1:0] group_col;

    modport source (output valid, output pixel_row, output group_col, input ready);
    modport sink   (input valid, input pixel_row, input group_col, output ready);
endinterface

// ===== sv/mbe_out_if.sv =====
interface mbe_out_if;
    import mbe_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count_lane0;
    logic [CNT_W-1:0] count_lane1;
    logic [CNT_W-1:0] count_lane2;
    logic [CNT_W-1:0] count_lane3;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_first_col;

    modport source (output valid, output count_lane0, output count_lane1,
                    output count_lane2, output count_lane3, output out_row,
                    output out_first_col, input ready);
    modport sink   (input valid, input count_lane0, input count_lane1,
                    input count_lane2, input count_lane3, input out_row,
                    input out_first_col, output ready);
endinterface

// ===== sv/mbe_lane.sv =====
module mbe_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mbe_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [mbe_pkg::OFF_W-1:0]     i_off,
    input  logic signed [mbe_pkg::Q_W-1:0]       i_x_origin,
    input  logic signed [mbe_pkg::Q_W-1:0]       i_x_step,
    input  logic signed [mbe_pkg::Q_W-1:0]       i_cy_next,
    input  logic signed [mbe_pkg::Q_W-1:0]       i_cy,
    input  logic [mbe_pkg::R2_W-1:0]             i_escape_r2,
    output logic                                 o_act,
    output logic [mbe_pkg::CNT_W-1:0]            o_count
);
    import mbe_pkg::*;

    logic signed [MPROD_W-1:0] r_prod;
    logic signed [Q_W-1:0]     r_cx;
    logic signed [Q_W-1:0]     r_x;
    logic signed [Q_W-1:0]     r_y;
    logic signed [SQ_W-1:0]    r_xx;
    logic signed [SQ_W-1:0]    r_yy;
    logic signed [SQ_W-1:0]    r_xy;
    logic                      r_active;
    logic [CNT_W-1:0]          r_count;

    logic signed [MPROD_W-1:0] w_prod;
    logic signed [SUM_W-1:0]   w_map_sum;
    logic signed [PROD_W-1:0]  w_pxx;
    logic signed [PROD_W-1:0]  w_pyy;
    logic signed [PROD_W-1:0]  w_pxy;
    logic signed [SQ_W:0]      w_mag;
    logic                      w_esc;
    logic                      w_act;
    logic signed [NEXT_W-1:0]  w_nx;
    logic signed [NEXT_W-1:0]  w_ny;

    assign w_prod    = i_off * i_x_step;
    assign w_map_sum = SUM_W'(i_x_origin) + SUM_W'(r_prod);

    assign w_pxx = r_x * r_x;
    assign w_pyy = r_y * r_y;
    assign w_pxy = r_x * r_y;

    // |z|^2 against radius, full width
    assign w_mag = (SQ_W+1)'(r_xx) + (SQ_W+1)'(r_yy);
    assign w_esc = w_mag > $signed({{(SQ_W+1-R2_W){1'b0}}, i_escape_r2});
    assign w_act = r_active & ~w_esc;

    assign w_nx = NEXT_W'(r_xx) - NEXT_W'(r_yy) + NEXT_W'(r_cx);
    assign w_ny = (NEXT_W'(r_xy) <<< 1) + NEXT_W'(i_cy);

    // offset products and squares; the squares drop their low bits, which floors
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_prod <= w_prod;
        end
        if (i_ctl.mul) begin
            r_xx <= w_pxx[PROD_W-1:FRAC];
            r_yy <= w_pyy[PROD_W-1:FRAC];
            r_xy <= w_pxy[PROD_W-1:FRAC];
        end
        if (i_ctl.map) begin
            r_cx <= sat_q(w_map_sum);
            r_x  <= sat_q(w_map_sum);
            r_y  <= i_cy_next;
        end else if (i_ctl.upd) begin
            r_x <= sat_q(SUM_W'(w_nx));
            r_y <= sat_q(SUM_W'(w_ny));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
        end else if (i_ctl.map) begin
            r_active <= 1'b1;
            r_count  <= '0;
        end else if (i_ctl.upd) begin
            r_active <= w_act;
            if (w_act) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    assign o_act   = w_act;
    assign o_count = r_count;

endmodule

// ===== sv/mbe_seq.sv =====
module mbe_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [mbe_pkg::ROW_W-1:0]         i_pixel_row,
    input  logic [mbe_pkg::GCOL_W-1:0]        i_group_col,
    input  logic signed [mbe_pkg::Q_W-1:0]    i_y_origin,
    input  logic signed [mbe_pkg::Q_W-1:0]    i_y_step,
    input  logic [mbe_pkg::CNT_W-1:0]         i_max_iter,
    input  logic                              i_any,
    input  logic                              i_out_free,
    output logic                              o_in_ready,
    output mbe_pkg::t_lane_ctl                o_ctl,
    output logic signed [mbe_pkg::Q_W-1:0]    o_cy_next,
    output logic signed [mbe_pkg::Q_W-1:0]    o_cy,
    output logic                              o_out_load,
    output logic [mbe_pkg::ROW_W-1:0]         o_row,
    output logic [mbe_pkg::COL_W-1:0]         o_first_col
);
    import mbe_pkg::*;

    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_W-1:0]          r_round;
    logic signed [MPROD_W-1:0] r_yprod;
    logic signed [Q_W-1:0]     r_cy;
    logic [ROW_W-1:0]          r_row;
    logic [COL_W-1:0]          r_first;

    logic signed [OFF_W-1:0]   w_row_off;
    logic signed [MPROD_W-1:0] w_yprod;
    logic signed [Q_W-1:0]     w_cy;
    logic                      w_last;

    assign w_row_off = OFF_W'(i_pixel_row) - OFF_W'(SCREEN_HEIGHT / 2);
    assign w_yprod   = w_row_off * i_y_step;
    assign w_cy      = sat_q(SUM_W'(i_y_origin) + SUM_W'(r_yprod));
    assign w_last    = ((CNT_W+1)'(r_round) + (CNT_W+1)'(1)) == (CNT_W+1)'(i_max_iter);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_accept) n_state = S_MAP;
            end
            S_MAP: begin
                n_state = (i_max_iter == '0) ? S_DRAIN : S_MUL;
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = (!i_any || w_last) ? S_DRAIN : S_MUL;
            end
            S_DRAIN: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_ctl.accept = i_accept;
        o_ctl.map    = (r_state == S_MAP);
        o_ctl.mul    = (r_state == S_MUL);
        o_ctl.upd    = (r_state == S_UPD);
        o_out_load   = (r_state == S_DRAIN) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MAP) begin
                r_round <= '0;
            end else if (r_state == S_UPD) begin
                r_round <= r_round + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_yprod <= w_yprod;
            r_row   <= i_pixel_row;
            r_first <= COL_W'(OFF_W'(i_group_col) * OFF_W'(LANES));
        end
        if (r_state == S_MAP) begin
            r_cy <= w_cy;
        end
    end

    assign o_cy_next   = w_cy;
    assign o_cy        = r_cy;
    assign o_row       = r_row;
    assign o_first_col = r_first;

`ifndef ASSERT_OFF
    a_round_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_round < i_max_iter))
        else $error("round counter past limit");

    a_accept_maps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_state == S_MAP))
        else $error("accepted word not mapped");

    a_all_escaped_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && !i_any) |=> (r_state == S_DRAIN))
        else $error("group kept running with no live lane");
`endif

endmodule

// ===== sv/mbe_merge.sv =====
module mbe_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [mbe_pkg::LANES-1:0]         i_act,
    input  logic [mbe_pkg::CNT_W-1:0]         i_count [mbe_pkg::LANES],
    input  logic                              i_load,
    input  logic [mbe_pkg::ROW_W-1:0]         i_row,
    input  logic [mbe_pkg::COL_W-1:0]         i_first_col,
    output logic                              o_any,
    output logic                              o_free,
    mbe_out_if.source                         o_out
);
    import mbe_pkg::*;

    logic             r_valid;
    logic [CNT_W-1:0] r_cnt [OUT_LANES];
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_first;
    logic [CNT_W-1:0] w_cnt [OUT_LANES];

    // any lane still counting after this round's escape test
    assign o_any  = |i_act;
    assign o_free = !r_valid || o_out.ready;

    // lanes past the reported ones still vote in o_any
    for (genvar k = 0; k < OUT_LANES; k++) begin : g_cnt
        if (k < LANES) begin : g_live
            assign w_cnt[k] = i_count[k];
        end else begin : g_none
            assign w_cnt[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt   <= w_cnt;
            r_row   <= i_row;
            r_first <= i_first_col;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.count_lane0   = r_cnt[0];
    assign o_out.count_lane1   = r_cnt[1];
    assign o_out.count_lane2   = r_cnt[2];
    assign o_out.count_lane3   = r_cnt[3];
    assign o_out.out_row       = r_row;
    assign o_out.out_first_col = r_first;

endmodule

// ===== sv/mandelbrot_escape_time_unit.sv =====
// Channel   | Dir | Handshake     | Word
// ----------+-----+---------------+-------------------------------------------
// i_in      | in  | valid / ready | pixel_row[9:0], group_col[7:0]
// o_out     | out | valid / ready | count_lane0..3[15:0], out_row, out_first_col
// i_cfg_*   | in  | we only       | idx[2:0] selects register, data[31:0]
//
// One word at a time. After acceptance the sequencer maps the pixels, then
// runs R rounds (square products, then escape test and z update), with
// R = min(max_iter, rounds until all lanes escaped), then hands the counts
// to the output register.
// Reset (i_rst_n low, synchronous) idles the sequencer, empties the output
// register and restores the register defaults.
// o_out stalls hold the next group in its drain step; input is taken again
// once the finished counts move into the output register.
module mandelbrot_escape_time_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mbe_in_if.sink                      i_in,
    mbe_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [mbe_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [mbe_pkg::CFG_W-1:0]   i_cfg_data
);
    import mbe_pkg::*;

    // configuration registers
    logic signed [Q_W-1:0] r_x_origin;
    logic signed [Q_W-1:0] r_y_origin;
    logic signed [Q_W-1:0] r_x_step;
    logic signed [Q_W-1:0] r_y_step;
    logic [CNT_W-1:0]      r_max_iter;
    logic [R2_W-1:0]       r_escape_r2;

    logic                  w_accept;
    logic                  w_in_ready;
    t_lane_ctl             w_ctl;
    logic signed [Q_W-1:0] w_cy_next;
    logic signed [Q_W-1:0] w_cy;
    logic                  w_any;
    logic                  w_free;
    logic                  w_out_load;
    logic [ROW_W-1:0]      w_row;
    logic [COL_W-1:0]      w_first_col;
    logic [LANES-1:0]      w_act;
    logic [CNT_W-1:0]      w_count [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin  <= X_ORIGIN_RST;
            r_y_origin  <= Y_ORIGIN_RST;
            r_x_step    <= X_STEP_RST;
            r_y_step    <= Y_STEP_RST;
            r_max_iter  <= MAX_ITER_RST;
            r_escape_r2 <= ESC_R2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_ORIGIN:  r_x_origin  <= i_cfg_data;
                CFG_Y_ORIGIN:  r_y_origin  <= i_cfg_data;
                CFG_X_STEP:    r_x_step    <= i_cfg_data;
                CFG_Y_STEP:    r_y_step    <= i_cfg_data;
                CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[CNT_W-1:0];
                CFG_ESCAPE_R2: r_escape_r2 <= i_cfg_data[R2_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    mbe_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_pixel_row (i_in.pixel_row),
        .i_group_col (i_in.group_col),
        .i_y_origin  (r_y_origin),
        .i_y_step    (r_y_step),
        .i_max_iter  (r_max_iter),
        .i_any       (w_any),
        .i_out_free  (w_free),
        .o_in_ready  (w_in_ready),
        .o_ctl       (w_ctl),
        .o_cy_next   (w_cy_next),
        .o_cy        (w_cy),
        .o_out_load  (w_out_load),
        .o_row       (w_row),
        .o_first_col (w_first_col)
    );

    // one lane per column of the group; column offset from screen center
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic [OFF_W-1:0]        w_col;
        logic signed [OFF_W-1:0] w_off;

        assign w_col = OFF_W'(i_in.group_col) * OFF_W'(LANES) + OFF_W'(i);
        assign w_off = w_col - OFF_W'(SCREEN_WIDTH / 2);

        mbe_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_off       (w_off),
            .i_x_origin  (r_x_origin),
            .i_x_step    (r_x_step),
            .i_cy_next   (w_cy_next),
            .i_cy        (w_cy),
            .i_escape_r2 (r_escape_r2),
            .o_act       (w_act[i]),
            .o_count     (w_count[i])
        );
    end

    mbe_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_act       (w_act),
        .i_count     (w_count),
        .i_load      (w_out_load),
        .i_row       (w_row),
        .i_first_col (w_first_col),
        .o_any       (w_any),
        .o_free      (w_free),
        .o_out       (o_out)
    );

endmodule

// ===== bench/tb_mandelbrot_escape_time_unit.sv =====
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time_unit;
    import mbe_pkg::*;

    localparam int     WATCHDOG_LIMIT = 400000;  // longest group stays well under this
    localparam int     TAIL_CYCLES    = 64;
    localparam int     LONG_HOLD      = 600;     // receiver hold-off, in cycles
    localparam int     MAX_REPORTS    = 10;
    localparam int     Q_ONE          = 1 << FRAC;
    localparam longint Q_MAX          = 64'sd2147483647;
    localparam longint Q_MIN          = -64'sd2147483648;

    // one input word: a row and a four-column group
    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [GCOL_W-1:0] gcol;
    } t_group_word;

    // one output word: per-lane round counts plus position
    typedef struct packed {
        logic [OUT_LANES-1:0][CNT_W-1:0] cnt;
        logic [ROW_W-1:0]                row;
        logic [COL_W-1:0]                col;
    } t_lane_counts;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    mbe_in_if  in_ch ();
    mbe_out_if out_ch ();

    mandelbrot_escape_time_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // view registers as the block should hold them
    int               x_org;
    int               y_org;
    int               x_stp;
    int               y_stp;
    logic [CNT_W-1:0] iter_lim;
    logic [R2_W-1:0]  r2_lim;

    t_group_word  pending_groups [$];
    t_lane_counts expected_counts [$];

    int  words_sent     = 0;   // words put on the input channel
    int  words_taken    = 0;   // words the block accepted
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  settings_used  = 0;
    int  longest_count  = 0;
    int  all_zero_words = 0;
    int  quiet_cycles   = 0;
    bit  gaps_on        = 1'b1;  // cleared for back-to-back stretches
    bit  hold_req       = 1'b0;  // asks the receiver for one long hold-off
    bit  hold_started   = 1'b0;
    int  hold_left      = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;

    function automatic int clamp_q(input longint v);
        if (v > Q_MAX) begin
            return int'(Q_MAX);
        end
        if (v < Q_MIN) begin
            return int'(Q_MIN);
        end
        return int'(v);
    endfunction

    // Escape-time counts for one group under the current view.
    // Products are exact then floored back to Q8.24 (arithmetic shift);
    // every stored coordinate clamps to 32 bits.
    function automatic t_lane_counts predict_escape_counts(input t_group_word w);
        t_lane_counts res;
        longint       first;
        int           cy;
        int           cx   [LANES];
        int           zx   [LANES];
        int           zy   [LANES];
        longint       xx   [LANES];
        longint       yy   [LANES];
        longint       xy   [LANES];
        bit           live [LANES];
        int           cnt  [LANES];
        bit           any;
        first = longint'(w.gcol) * LANES;
        cy = clamp_q(longint'(y_org)
                     + (longint'(w.row) - SCREEN_HEIGHT / 2) * longint'(y_stp));
        for (int i = 0; i < LANES; i++) begin
            cx[i]   = clamp_q(longint'(x_org)
                              + (first + i - SCREEN_WIDTH / 2) * longint'(x_stp));
            zx[i]   = cx[i];
            zy[i]   = cy;
            live[i] = 1'b1;
            cnt[i]  = 0;
        end
        for (int n = 0; n < int'(iter_lim); n++) begin
            any = 1'b0;
            for (int i = 0; i < LANES; i++) begin
                xx[i] = (longint'(zx[i]) * longint'(zx[i])) >>> FRAC;
                yy[i] = (longint'(zy[i]) * longint'(zy[i])) >>> FRAC;
                xy[i] = (longint'(zx[i]) * longint'(zy[i])) >>> FRAC;
                // escape test is exact, no wrap
                if (xx[i] + yy[i] > longint'(r2_lim)) begin
                    live[i] = 1'b0;
                end
                if (live[i]) begin
                    any = 1'b1;
                end
            end
            if (!any) begin
                break;
            end
            for (int i = 0; i < LANES; i++) begin
                if (live[i]) begin
                    cnt[i]++;
                end
                // escaped lanes keep iterating; their values never count again
                zx[i] = clamp_q(xx[i] - yy[i] + cx[i]);
                zy[i] = clamp_q(2 * xy[i] + cy);
            end
        end
        for (int i = 0; i < OUT_LANES; i++) begin
            res.cnt[i] = (i < LANES) ? cnt[i][CNT_W-1:0] : '0;
        end
        res.row = w.row;
        res.col = first[COL_W-1:0];
        return res;
    endfunction

    // gap lengths: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_edge_q();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Input driver: offers words from pending_groups at the falling edge.
    // A word stays up until taken; idle gaps only fall between words.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        t_group_word w;
        if (i_rst_n) begin
            if (words_sent == words_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_groups.size() > 0) begin
                    w = pending_groups.pop_front();
                    in_ch.pixel_row <= w.row;
                    in_ch.group_col <= w.gcol;
                    in_ch.valid     <= 1'b1;
                    words_sent++;
                    send_gap = pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // input side: every accepted word gets its expected counts
    always @(posedge i_clk) begin
        t_group_word w;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            w.row  = in_ch.pixel_row;
            w.gcol = in_ch.group_col;
            expected_counts.push_back(predict_escape_counts(w));
            words_taken++;
        end
    end

    // ---------------------------------------------------------------
    // Output ready: random stalls, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering words
    // and the block backs up into its input.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_req && !hold_started) begin
                hold_started = 1'b1;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // output checker: oldest expectation against each accepted word
    always @(posedge i_clk) begin
        t_lane_counts got;
        t_lane_counts want;
        bit           bad;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.cnt[0] = out_ch.count_lane0;
            got.cnt[1] = out_ch.count_lane1;
            got.cnt[2] = out_ch.count_lane2;
            got.cnt[3] = out_ch.count_lane3;
            got.row    = out_ch.out_row;
            got.col    = out_ch.out_first_col;
            results_seen++;
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected word row %0d col %0d", $realtime,
                             got.row, got.col);
                end
            end else begin
                want = expected_counts.pop_front();
                bad  = (got.row !== want.row) || (got.col !== want.col);
                for (int i = 0; i < OUT_LANES; i++) begin
                    if (got.cnt[i] !== want.cnt[i]) begin
                        bad = 1'b1;
                    end
                end
                if (bad) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: mismatch exp row %0d col %0d cnt %0d %0d %0d %0d",
                                 $realtime, want.row, want.col, want.cnt[0],
                                 want.cnt[1], want.cnt[2], want.cnt[3]);
                        $display("          got row %0d col %0d cnt %0d %0d %0d %0d",
                                 got.row, got.col, got.cnt[0], got.cnt[1],
                                 got.cnt[2], got.cnt[3]);
                    end
                end
                for (int i = 0; i < OUT_LANES; i++) begin
                    if (int'(want.cnt[i]) > longest_count) begin
                        longest_count = int'(want.cnt[i]);
                    end
                end
                if (want.cnt == '0) begin
                    all_zero_words++;
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles", quiet_cycles);
                $display("[mandelbrot_escape_time_unit] ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Register writes: one per falling edge, enable dropped afterwards.
    // Upper bits beyond a register's width get junk; the block drops them.
    // ---------------------------------------------------------------
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_X_ORIGIN:  x_org    = int'(val);
            CFG_Y_ORIGIN:  y_org    = int'(val);
            CFG_X_STEP:    x_stp    = int'(val);
            CFG_Y_STEP:    y_stp    = int'(val);
            CFG_MAX_ITER:  iter_lim = val[CNT_W-1:0];
            CFG_ESCAPE_R2: r2_lim   = val[R2_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_view(input logic [31:0] xo, input logic [31:0] yo,
                            input logic [31:0] xs, input logic [31:0] ys,
                            input logic [CNT_W-1:0] mi, input logic [R2_W-1:0] r2);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(CFG_X_ORIGIN, xo);
        write_reg(CFG_Y_ORIGIN, yo);
        write_reg(CFG_X_STEP, xs);
        write_reg(CFG_Y_STEP, ys);
        write_reg(CFG_MAX_ITER, {junk, mi});
        write_reg(CFG_ESCAPE_R2, {junk[0], r2});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_group(input int row, input int gcol);
        t_group_word w;
        w.row  = row[ROW_W-1:0];
        w.gcol = gcol[GCOL_W-1:0];
        pending_groups.push_back(w);
    endtask

    // block is idle once nothing is queued, offered or owed
    task automatic wait_drained();
        while (pending_groups.size() != 0 || words_sent != words_taken ||
               expected_counts.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // random view: mostly around the set boundary, else raw or edge values
    task automatic pick_random_view();
        int               r;
        logic [31:0]      q [4];
        logic [CNT_W-1:0] mi;
        logic [R2_W-1:0]  r2;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            q[0] = int'($urandom_range(0, 45_297_664)) - 35_232_153;
            q[1] = int'($urandom_range(0, 33_554_432)) - 16_777_216;
            q[2] = int'($urandom_range(1000, 120000)) * ($urandom_range(0, 3) == 0 ? -1 : 1);
            q[3] = int'($urandom_range(1000, 120000)) * ($urandom_range(0, 3) == 0 ? -1 : 1);
        end else if (r < 85) begin
            for (int i = 0; i < 4; i++) begin
                q[i] = $urandom;
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                q[i] = pick_edge_q();
            end
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            mi = '0;
        end else if (r < 15) begin
            mi = CNT_W'($urandom_range(65, 200));
        end else begin
            mi = CNT_W'($urandom_range(1, 64));
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            r2 = R2_W'(4 * Q_ONE);
        end else if (r < 85) begin
            r2 = R2_W'($urandom);
        end else begin
            case ($urandom_range(0, 2))
                0:       r2 = '0;
                1:       r2 = '1;
                default: r2 = R2_W'(1);
            endcase
        end
        set_view(q[0], q[1], q[2], q[3], mi, r2);
    endtask

    task automatic run_random_phase(input int n_words);
        int r;
        pick_random_view();
        for (int k = 0; k < n_words; k++) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                queue_group($urandom_range(0, SCREEN_HEIGHT - 1),
                            $urandom_range(0, SCREEN_WIDTH / LANES - 1));
            end else begin
                // off-screen rows and columns are still mapped
                queue_group($urandom_range(0, (1 << ROW_W) - 1),
                            $urandom_range(0, (1 << GCOL_W) - 1));
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_X_ORIGIN;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.pixel_row = '0;
        in_ch.group_col = '0;
        out_ch.ready    = 1'b0;
        x_org    = X_ORIGIN_RST;
        y_org    = Y_ORIGIN_RST;
        x_stp    = X_STEP_RST;
        y_stp    = Y_STEP_RST;
        iter_lim = MAX_ITER_RST;
        r2_lim   = ESC_R2_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset view: corners, center, off-screen, alternating bits
        queue_group(0, 0);
        queue_group(599, 199);
        queue_group(300, 100);
        queue_group(1023, 255);
        queue_group(0, 255);
        queue_group(1023, 0);
        queue_group(341, 85);
        queue_group(682, 170);
        wait_drained();

        // zero limit: all counts zero
        set_view(0, 0, X_STEP_RST, Y_STEP_RST, 0, ESC_R2_RST);
        queue_group(300, 100);
        queue_group(1023, 255);
        wait_drained();

        // extreme origins and steps: mapping clamps, widest radius
        set_view(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 16, '1);
        queue_group(0, 0);
        queue_group(1023, 255);
        queue_group(300, 100);
        wait_drained();

        // zero radius with tiny coordinates: floor rounding of negatives
        set_view(0, 0, 4096, -4096, 30, '0);
        queue_group(300, 100);
        queue_group(0, 0);
        queue_group(301, 99);
        wait_drained();

        // c = 0 never escapes: full 16-bit count
        set_view(0, 0, 0, 0, '1, ESC_R2_RST);
        queue_group(300, 100);
        wait_drained();

        for (int p = 0; p < 11; p++) begin
            gaps_on = (p % 3) != 0;
            if (p == 1) begin
                hold_req = 1'b1;
            end
            run_random_phase(110);
        end

        // back to the reset view at the default limit
        gaps_on = 1'b1;
        set_view(X_ORIGIN_RST, Y_ORIGIN_RST, X_STEP_RST, Y_STEP_RST,
                 MAX_ITER_RST, ESC_R2_RST);
        for (int k = 0; k < 60; k++) begin
            queue_group($urandom_range(0, SCREEN_HEIGHT - 1),
                        $urandom_range(0, SCREEN_WIDTH / LANES - 1));
        end
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_counts.size() != 0) begin
            mismatches += expected_counts.size();
            $display("%0d expected words never arrived", expected_counts.size());
        end
        $display("coverage: %0d groups in, %0d results out, %0d register settings",
                 words_taken, results_seen, settings_used);
        $display("coverage: longest count %0d, %0d groups escaped at once, %0d mismatches",
                 longest_count, all_zero_words, mismatches);
        if (mismatches == 0) begin
            $display("[mandelbrot_escape_time_unit] OK");
        end else begin
            $display("[mandelbrot_escape_time_unit] ERROR");
        end
        $finish;
    end

endmodule
